FILE: sv/moc_pkg.sv
// Shared types and codes of the magazine object cache.
package moc_pkg;

    // Request kind, carried in the input tuser.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // How a request was served, carried in the output tuser.
    typedef enum logic [1:0] {
        OUT_LOADED = 2'd0,
        OUT_SWAP   = 2'd1,
        OUT_DEPOT  = 2'd2,
        OUT_MISS   = 2'd3
    } outcome_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ACCESS,
        ST_POP
    } state_t;

    // Decision taken once the magazine counts are known.
    typedef enum logic [2:0] {
        PLAN_LOADED,
        PLAN_SWAP,
        PLAN_STACK,
        PLAN_FRESH,
        PLAN_MISS
    } plan_t;

    // Commands from the controller to the depot.
    typedef struct packed {
        logic pop_full;
        logic pop_empty;
        logic push_full;
        logic push_empty;
        logic issue;
    } depot_cmd_t;

    // Depot status seen by the controller.
    typedef struct packed {
        logic full_avail;
        logic empty_avail;
        logic fresh_avail;
    } depot_status_t;

endpackage

FILE: sv/moc_mag_store.sv
// Magazine store: the round slots of every magazine and their round counts.
module moc_mag_store #(
    parameter int POOL   = 32,
    parameter int ROUNDS = 16
) (
    input  logic                                 clk,
    input  logic                                 cnt_re_a,
    input  logic [$clog2(POOL)-1:0]              cnt_raddr_a,
    output logic [$clog2(ROUNDS+1)-1:0]          cnt_rdata_a,
    input  logic                                 cnt_re_b,
    input  logic [$clog2(POOL)-1:0]              cnt_raddr_b,
    output logic [$clog2(ROUNDS+1)-1:0]          cnt_rdata_b,
    input  logic                                 cnt_we,
    input  logic [$clog2(POOL)-1:0]              cnt_waddr,
    input  logic [$clog2(ROUNDS+1)-1:0]          cnt_wdata,
    input  logic                                 slot_re,
    input  logic [$clog2(POOL*ROUNDS)-1:0]       slot_raddr,
    output logic [31:0]                          slot_rdata,
    input  logic                                 slot_we,
    input  logic [$clog2(POOL*ROUNDS)-1:0]       slot_waddr,
    input  logic [31:0]                          slot_wdata
);

    localparam int DEPTH = POOL * ROUNDS;
    localparam int RW    = $clog2(ROUNDS + 1);

    logic [31:0]   slot_mem  [DEPTH];
    logic [RW-1:0] count_mem [POOL];

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rdata <= slot_mem[slot_raddr];
        end
    end

    // Two read ports serve the loaded and the previous magazine at once.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re_a)
        begin
            cnt_rdata_a <= count_mem[cnt_raddr_a];
        end
        if (cnt_re_b)
        begin
            cnt_rdata_b <= count_mem[cnt_raddr_b];
        end
    end

endmodule

FILE: sv/moc_depot.sv
// Depot: stacks of full and empty magazines and the fresh magazine counter.
module moc_depot #(
    parameter int POOL = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  moc_pkg::depot_cmd_t        cmd,
    input  logic [$clog2(POOL)-1:0]    push_mag,
    output logic [$clog2(POOL)-1:0]    full_top,
    output logic [$clog2(POOL)-1:0]    empty_top,
    output logic [$clog2(POOL)-1:0]    fresh_mag,
    output moc_pkg::depot_status_t     status
);

    import moc_pkg::*;

    localparam int MW  = $clog2(POOL);
    localparam int CNW = $clog2(POOL + 1);
    localparam logic [CNW-1:0] POOL_CNT = CNW'(POOL);

    logic [MW-1:0]  full_mem  [POOL];
    logic [MW-1:0]  empty_mem [POOL];
    logic [CNW-1:0] full_cnt_reg;
    logic [CNW-1:0] empty_cnt_reg;
    logic [CNW-1:0] issued_reg;
    logic [CNW-1:0] full_cnt_next;
    logic [CNW-1:0] empty_cnt_next;
    logic [CNW-1:0] issued_next;
    logic           full_room;
    logic           empty_room;

    assign full_room  = full_cnt_reg < POOL_CNT;
    assign empty_room = empty_cnt_reg < POOL_CNT;

    assign status.full_avail  = full_cnt_reg != '0;
    assign status.empty_avail = empty_cnt_reg != '0;
    assign status.fresh_avail = issued_reg < POOL_CNT;
    assign fresh_mag          = MW'(issued_reg);

    always_comb
    begin
        full_cnt_next  = full_cnt_reg;
        empty_cnt_next = empty_cnt_reg;
        issued_next    = issued_reg;
        if (cmd.pop_full)
        begin
            full_cnt_next = full_cnt_reg - CNW'(1);
        end
        else if (cmd.push_full && full_room)
        begin
            full_cnt_next = full_cnt_reg + CNW'(1);
        end
        if (cmd.pop_empty)
        begin
            empty_cnt_next = empty_cnt_reg - CNW'(1);
        end
        else if (cmd.push_empty && empty_room)
        begin
            empty_cnt_next = empty_cnt_reg + CNW'(1);
        end
        if (cmd.issue)
        begin
            issued_next = issued_reg + CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_cnt_reg  <= '0;
            empty_cnt_reg <= '0;
            issued_reg    <= '0;
        end
        else
        begin
            full_cnt_reg  <= full_cnt_next;
            empty_cnt_reg <= empty_cnt_next;
            issued_reg    <= issued_next;
        end
    end

    // The top of each stack is read ahead, when the request is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.push_full && full_room)
        begin
            full_mem[MW'(full_cnt_reg)] <= push_mag;
        end
        if (cmd.push_empty && empty_room)
        begin
            empty_mem[MW'(empty_cnt_reg)] <= push_mag;
        end
        if (rd_en)
        begin
            full_top  <= full_mem[MW'(full_cnt_reg - CNW'(1))];
            empty_top <= empty_mem[MW'(empty_cnt_reg - CNW'(1))];
        end
    end

endmodule

FILE: sv/magazine_object_cache.sv
// Top level of the magazine object cache: request control and per-CPU magazine pairs.
//
// Per-CPU object cache in front of a slab allocator. Each CPU has a loaded and a
// previous magazine, each a stack of up to ROUNDS_PER_MAGAZINE object addresses held
// in a synchronous slot memory, with the round count of every magazine in a second
// synchronous memory. A request on the input stream (tuser: 0 allocate, 1 free;
// tdata: CPU index, then the object address) is taken only while the controller is
// idle, and it yields exactly one result on the output stream (tdata: the address
// handed out, zero on a free or a miss; tuser: 0 loaded magazine, 1 after a swap with
// previous, 2 after a depot exchange, 3 miss to the slab layer). The result waits in
// an output register, so the next request can be taken before it is collected. The
// result register is loaded in the decide state for a miss, in the access state for
// a free or an allocate that finds no round, and in the pop state for any other
// allocate; the controller is back in idle at that same edge. Each read of the count
// memory is registered (counts first, then the slot address), and so is the slot
// memory read that the pop state hands out. A stalled output holds the controller in
// its final state until the result register is free. The enable register, written
// over the cfg channel, turns every request into a miss when it is cleared; it must
// only be written while no request is in flight.
module magazine_object_cache #(
    parameter int ROUNDS_PER_MAGAZINE = 16,
    parameter int MAGAZINE_POOL       = 32,
    parameter int NUM_CPUS            = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] cpu_index, [33:2] object_address, rest zero
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] allocated_address
    output logic [1:0]  m_tuser,   // [1:0] outcome
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // magazine_layer_enable
);

    import moc_pkg::*;

    localparam int MW  = $clog2(MAGAZINE_POOL);
    localparam int RW  = $clog2(ROUNDS_PER_MAGAZINE + 1);
    localparam int SAW = $clog2(MAGAZINE_POOL * ROUNDS_PER_MAGAZINE);
    localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [RW-1:0] ROUNDS    = RW'(ROUNDS_PER_MAGAZINE);
    localparam logic [2:0]    CPU_LIMIT = 3'((NUM_CPUS > 4) ? 4 : NUM_CPUS);

    // Request as taken from the stream.
    logic          accept;
    op_t           in_op;
    logic [1:0]    in_cpu;
    logic [31:0]   in_obj;
    logic [CW-1:0] in_idx;

    // Controller state and request registers.
    state_t        state_reg;
    state_t        state_next;
    op_t           req_op_reg;
    logic [1:0]    req_cpu_reg;
    logic [31:0]   req_obj_reg;
    logic [MW-1:0] tgt_mag_reg;
    logic [RW-1:0] cnt_reg;
    logic          cnt_mem_reg;
    outcome_t      outcome_reg;
    logic          enable_reg;

    // Per-CPU magazine pairs.
    logic          ld_v_reg   [NUM_CPUS];
    logic [MW-1:0] ld_mag_reg [NUM_CPUS];
    logic          pv_v_reg   [NUM_CPUS];
    logic [MW-1:0] pv_mag_reg [NUM_CPUS];

    // Output register.
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   out_addr_reg;
    outcome_t      out_outcome_reg;
    logic          out_free;
    logic          load_out;
    logic [31:0]   out_addr_new;
    outcome_t      out_outcome_new;

    // Decision terms.
    logic [CW-1:0] cur;
    logic          in_range;
    logic          ld_v;
    logic          pv_v;
    logic [MW-1:0] ld_mag;
    logic [MW-1:0] pv_mag;
    plan_t         plan;
    logic [MW-1:0] stack_top;
    logic [MW-1:0] new_mag;
    logic [RW-1:0] acc_cnt;
    logic [RW-1:0] slot_pos;
    logic [SAW-1:0] slot_addr;

    // Store and depot connections.
    logic          cnt_re_a;
    logic [MW-1:0] cnt_raddr_a;
    logic [RW-1:0] cnt_rdata_a;
    logic          cnt_re_b;
    logic [MW-1:0] cnt_raddr_b;
    logic [RW-1:0] cnt_rdata_b;
    logic          cnt_we;
    logic [RW-1:0] cnt_wdata;
    logic          slot_re;
    logic [31:0]   slot_rdata;
    logic          slot_we;
    depot_cmd_t    dcmd;
    depot_status_t dstat;
    logic [MW-1:0] full_top;
    logic [MW-1:0] empty_top;
    logic [MW-1:0] fresh_mag;

    assign in_op  = op_t'(s_tuser[0]);
    assign in_cpu = s_tdata[1:0];
    assign in_obj = s_tdata[33:2];
    assign in_idx = CW'(in_cpu);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_outcome_reg;
    assign out_free = !out_valid_reg || m_tready;

    // The counts of the loaded and the previous magazine arrive with the decide state.
    assign cur      = CW'(req_cpu_reg);
    assign in_range = {1'b0, req_cpu_reg} < CPU_LIMIT;
    assign ld_v     = ld_v_reg[cur];
    assign pv_v     = pv_v_reg[cur];
    assign ld_mag   = ld_mag_reg[cur];
    assign pv_mag   = pv_mag_reg[cur];

    always_comb
    begin
        plan = PLAN_MISS;
        if (enable_reg && in_range)
        begin
            if (req_op_reg == OP_ALLOC)
            begin
                if (ld_v && cnt_rdata_a != '0)
                begin
                    plan = PLAN_LOADED;
                end
                else if (ld_v && pv_v && cnt_rdata_b != '0)
                begin
                    plan = PLAN_SWAP;
                end
                else if (dstat.full_avail)
                begin
                    plan = PLAN_STACK;
                end
            end
            else
            begin
                if (ld_v && cnt_rdata_a < ROUNDS)
                begin
                    plan = PLAN_LOADED;
                end
                else if (ld_v && pv_v && cnt_rdata_b < ROUNDS)
                begin
                    plan = PLAN_SWAP;
                end
                else if (dstat.empty_avail)
                begin
                    plan = PLAN_STACK;
                end
                else if (dstat.fresh_avail)
                begin
                    plan = PLAN_FRESH;
                end
            end
        end
    end

    // An allocate takes a full magazine from the depot, a free an empty one.
    assign stack_top = (req_op_reg == OP_ALLOC) ? full_top : empty_top;
    assign new_mag   = (plan == PLAN_FRESH) ? fresh_mag : stack_top;

    // In the access state the count comes either from the decision or, for a
    // magazine taken from a depot stack, straight from the count memory.
    assign acc_cnt   = cnt_mem_reg ? cnt_rdata_a : cnt_reg;
    assign slot_pos  = (req_op_reg == OP_ALLOC) ? acc_cnt - RW'(1) : acc_cnt;
    assign slot_addr = SAW'(tgt_mag_reg) * SAW'(ROUNDS_PER_MAGAZINE) + SAW'(slot_pos);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (plan != PLAN_MISS)
                begin
                    state_next = ST_ACCESS;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACCESS:
            begin
                if (req_op_reg == OP_ALLOC && acc_cnt != '0)
                begin
                    state_next = ST_POP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory, depot and output controls.
    always_comb
    begin
        cnt_re_a        = 1'b0;
        cnt_raddr_a     = ld_mag_reg[in_idx];
        cnt_re_b        = 1'b0;
        cnt_raddr_b     = pv_mag_reg[in_idx];
        cnt_we          = 1'b0;
        cnt_wdata       = acc_cnt + RW'(1);
        slot_re         = 1'b0;
        slot_we         = 1'b0;
        dcmd            = '0;
        load_out        = 1'b0;
        out_addr_new    = '0;
        out_outcome_new = outcome_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_re_a = accept;
                cnt_re_b = accept;
            end
            ST_DECIDE:
            begin
                out_outcome_new = OUT_MISS;
                cnt_raddr_a     = stack_top;
                case (plan)
                    PLAN_STACK:
                    begin
                        cnt_re_a        = 1'b1;
                        dcmd.pop_full   = (req_op_reg == OP_ALLOC);
                        dcmd.pop_empty  = (req_op_reg == OP_FREE);
                        dcmd.push_empty = (req_op_reg == OP_ALLOC) && pv_v;
                        dcmd.push_full  = (req_op_reg == OP_FREE) && pv_v;
                    end
                    PLAN_FRESH:
                    begin
                        dcmd.issue     = 1'b1;
                        dcmd.push_full = pv_v;
                    end
                    PLAN_MISS:
                    begin
                        load_out = out_free;
                    end
                    default:
                    begin
                        load_out = 1'b0;
                    end
                endcase
            end
            ST_ACCESS:
            begin
                if (req_op_reg == OP_ALLOC)
                begin
                    cnt_wdata = acc_cnt - RW'(1);
                    if (acc_cnt != '0)
                    begin
                        cnt_we  = 1'b1;
                        slot_re = 1'b1;
                    end
                    else
                    begin
                        load_out = out_free;
                    end
                end
                else
                begin
                    load_out = out_free;
                    if (out_free && acc_cnt < ROUNDS)
                    begin
                        cnt_we  = 1'b1;
                        slot_we = 1'b1;
                    end
                end
            end
            ST_POP:
            begin
                load_out     = out_free;
                out_addr_new = slot_rdata;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
            cnt_mem_reg   <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                ld_v_reg[i] <= 1'b0;
                pv_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                enable_reg <= cfg_data;
            end
            if (state_reg == ST_DECIDE)
            begin
                cnt_mem_reg <= (plan == PLAN_STACK);
                case (plan)
                    PLAN_SWAP:
                    begin
                        ld_v_reg[cur] <= pv_v;
                        pv_v_reg[cur] <= ld_v;
                    end
                    PLAN_STACK, PLAN_FRESH:
                    begin
                        ld_v_reg[cur] <= 1'b1;
                        pv_v_reg[cur] <= ld_v;
                    end
                    default:
                    begin
                        ld_v_reg[cur] <= ld_v;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg  <= in_op;
            req_cpu_reg <= in_cpu;
            req_obj_reg <= in_obj;
        end
        if (load_out)
        begin
            out_addr_reg    <= out_addr_new;
            out_outcome_reg <= out_outcome_new;
        end
        if (state_reg == ST_DECIDE)
        begin
            case (plan)
                PLAN_LOADED:
                begin
                    tgt_mag_reg <= ld_mag;
                    cnt_reg     <= cnt_rdata_a;
                    outcome_reg <= OUT_LOADED;
                end
                PLAN_SWAP:
                begin
                    ld_mag_reg[cur] <= pv_mag;
                    pv_mag_reg[cur] <= ld_mag;
                    tgt_mag_reg     <= pv_mag;
                    cnt_reg         <= cnt_rdata_b;
                    outcome_reg     <= OUT_SWAP;
                end
                PLAN_STACK, PLAN_FRESH:
                begin
                    ld_mag_reg[cur] <= new_mag;
                    pv_mag_reg[cur] <= ld_mag;
                    tgt_mag_reg     <= new_mag;
                    cnt_reg         <= '0;
                    outcome_reg     <= OUT_DEPOT;
                end
                default:
                begin
                    outcome_reg <= OUT_MISS;
                end
            endcase
        end
    end

    moc_mag_store #(
        .POOL   (MAGAZINE_POOL),
        .ROUNDS (ROUNDS_PER_MAGAZINE)
    ) u_store (
        .clk         (clk),
        .cnt_re_a    (cnt_re_a),
        .cnt_raddr_a (cnt_raddr_a),
        .cnt_rdata_a (cnt_rdata_a),
        .cnt_re_b    (cnt_re_b),
        .cnt_raddr_b (cnt_raddr_b),
        .cnt_rdata_b (cnt_rdata_b),
        .cnt_we      (cnt_we),
        .cnt_waddr   (tgt_mag_reg),
        .cnt_wdata   (cnt_wdata),
        .slot_re     (slot_re),
        .slot_raddr  (slot_addr),
        .slot_rdata  (slot_rdata),
        .slot_we     (slot_we),
        .slot_waddr  (slot_addr),
        .slot_wdata  (req_obj_reg)
    );

    moc_depot #(
        .POOL (MAGAZINE_POOL)
    ) u_depot (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .cmd       (dcmd),
        .push_mag  (pv_mag),
        .full_top  (full_top),
        .empty_top (empty_top),
        .fresh_mag (fresh_mag),
        .status    (dstat)
    );

endmodule

FILE: sv/moc_checker.sv
// Port-level checks of the magazine object cache and their binding to the top level.
module moc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    import moc_pkg::*;

    // A result that is not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss never hands out an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == OUT_MISS |-> m_tdata == 32'd0)
        else $error("miss carries a non-zero address");

    // One request is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    // No result appears in the cycle straight after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind magazine_object_cache moc_checker u_moc_checker (.*);
